// ===== src/ggc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared types and constants of the first-fit greedy graph coloring core.
// ----------------------------------------------------------------------------
package ggc_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned COLOR_LIMIT_DEF  = 64;
  localparam int unsigned MAX_DEGREE_DEF   = 64;

  // fixed field widths
  localparam int unsigned VERTEX_W = 12;
  localparam int unsigned COLOR_W  = 6;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned NODES_W  = 13;
  localparam int unsigned DSUM_W   = 19;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 13'd4096;
  localparam logic [NODES_W-1:0] NODES_MAX    = 13'h1FFF;
  localparam logic [DSUM_W-1:0]  DSUM_MAX     = 19'h7FFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;

  typedef enum logic [1:0] {
    ACT_NEIGHBOR = 2'd0,
    ACT_SOLO     = 2'd1,
    ACT_CLEAR    = 2'd2
  } ggc_action_e;

  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } ggc_state_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbor;
    logic                last;
  } ggc_in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex_out;
    logic [COLOR_W-1:0]  color_out;
    logic                ran_out;
    logic [COLOR_W-1:0]  colors_used;
    logic [NODES_W-1:0]  nodes_in_color;
    logic [DSUM_W-1:0]   neighbors_in_color;
  } ggc_out_t;

  // classified item handed from the front to the back
  typedef struct packed {
    ggc_action_e         kind;
    logic                fin;
    logic                in_range;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbor;
  } ggc_cmd_t;

  typedef struct packed {
    logic     valid;
    ggc_cmd_t cmd;
  } ggc_qhead_t;

  typedef struct packed {
    logic [NODES_W-1:0] nodes;
    logic [DSUM_W-1:0]  dsum;
  } ggc_stat_t;

endpackage

// ===== src/ggc_ram.sv =====
// ----------------------------------------------------------------------------
// ggc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read during write returns the old data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ggc_fifo.sv =====
// ----------------------------------------------------------------------------
// ggc_fifo
// Small register FIFO used for the command queue and the result buffer.
// ----------------------------------------------------------------------------
module ggc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o,
  output logic [NW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + NW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == NW'(DEPTH));
  assign count_o = count_q;

endmodule

// ===== src/ggc_front.sv =====
// ----------------------------------------------------------------------------
// ggc_front
// Input side: holds vertex_count, classifies each item and queues it unless its action is unknown.
// ----------------------------------------------------------------------------
module ggc_front #(
  parameter int unsigned MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ggc_pkg::ggc_in_t               in_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ggc_pkg::COUNT_W-1:0]    cfg_data_i,
  output ggc_pkg::ggc_qhead_t            head_o,
  input  logic                           pop_i
);

  logic [ggc_pkg::COUNT_W-1:0] vcount_q;
  ggc_pkg::ggc_cmd_t           cmd;
  ggc_pkg::ggc_cmd_t           head_cmd;
  logic                        keep;
  logic                        push;
  logic                        q_full;
  logic                        q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= ggc_pkg::VCOUNT_RESET;
    end else if (cfg_valid_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  always_comb begin
    cmd.vertex   = in_data_i.vertex;
    cmd.neighbor = in_data_i.neighbor;
    cmd.in_range = ({1'b0, in_data_i.neighbor} < vcount_q)
                   && (32'(in_data_i.neighbor) < MAX_VERTICES);
    cmd.kind     = ggc_pkg::ACT_NEIGHBOR;
    cmd.fin      = 1'b0;
    keep         = 1'b1;
    case (in_data_i.action)
      ggc_pkg::ACT_NEIGHBOR: begin
        cmd.kind = ggc_pkg::ACT_NEIGHBOR;
        cmd.fin  = in_data_i.last;
      end
      ggc_pkg::ACT_SOLO: begin
        cmd.kind = ggc_pkg::ACT_SOLO;
        cmd.fin  = 1'b1;
      end
      ggc_pkg::ACT_CLEAR: begin
        cmd.kind = ggc_pkg::ACT_CLEAR;
      end
      default: begin
        // unknown action is dropped here
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !in_stall_o && keep;

  ggc_fifo #(
    .WIDTH ($bits(ggc_pkg::ggc_cmd_t)),
    .DEPTH (ggc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd),
    .pop_i   (pop_i),
    .rdata_o (head_cmd),
    .valid_o (q_valid),
    .full_o  (q_full),
    .count_o ()
  );

  assign head_o.valid = q_valid;
  assign head_o.cmd   = head_cmd;

endmodule

// ===== src/ggc_back.sv =====
// ----------------------------------------------------------------------------
// ggc_back
// Execution side: color lookup, mask update and color choice, statistics
// update, result buffer. Also runs the color table clearing pass.
// ----------------------------------------------------------------------------
module ggc_back #(
  parameter int unsigned MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COLOR_LIMIT  = ggc_pkg::COLOR_LIMIT_DEF,
  parameter int unsigned MAX_DEGREE   = ggc_pkg::MAX_DEGREE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ggc_pkg::ggc_qhead_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ggc_pkg::ggc_out_t   out_data_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(COLOR_LIMIT);
  localparam int unsigned UW  = COLOR_LIMIT - 1;
  localparam int unsigned DW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned OCW = $clog2(ggc_pkg::OUT_DEPTH + 1);
  localparam int unsigned SW  = ggc_pkg::DSUM_W + 1;
  localparam logic [CW-1:0] Uncolored = CW'(COLOR_LIMIT - 1);

  // control
  ggc_pkg::ggc_state_e state_q, state_d;
  logic [VW-1:0]       clr_addr_q, clr_addr_d;
  logic                issue;
  logic                room;
  logic [OCW:0]        pending;
  logic [OCW-1:0]      out_count;

  // color table port
  logic                vram_we;
  logic [VW-1:0]       vram_waddr;
  logic [CW-1:0]       vram_wdata;
  logic [CW-1:0]       vram_rdata;

  // mark stage
  logic                b_valid_q;
  ggc_pkg::ggc_cmd_t   b_cmd_q;
  logic [UW-1:0]       mask_q;
  logic [DW-1:0]       deg_q;
  logic                stop_q;
  logic [CW-1:0]       ct_q;
  logic                wb_valid_q;
  logic [VW-1:0]       wb_addr_q;
  logic [CW-1:0]       wb_data_q;
  logic [CW-1:0]       c_sel;
  logic                mark;
  logic [DW-1:0]       deg_inc;
  logic [UW-1:0]       mask_mk;
  logic [UW-1:0]       mask_f;
  logic [DW-1:0]       deg_f;
  logic [UW-1:0]       avail;
  logic                found;
  logic [CW-1:0]       pick;
  logic                b_fin;
  logic                fail;
  logic                fresh;
  logic [CW-1:0]       chosen;
  logic [CW-1:0]       ct_n;
  logic                b_wen;

  // statistics stage
  logic                c_valid_q;
  logic [ggc_pkg::VERTEX_W-1:0] c_vertex_q;
  logic [CW-1:0]       c_chosen_q;
  logic                c_fail_q;
  logic                c_fresh_q;
  logic [DW-1:0]       c_deg_q;
  logic [CW-1:0]       c_ct_q;
  logic                sb_valid_q;
  logic [CW-1:0]       sb_addr_q;
  ggc_pkg::ggc_stat_t  sb_data_q;
  logic [$bits(ggc_pkg::ggc_stat_t)-1:0] st_rdata;
  ggc_pkg::ggc_stat_t  st_old;
  ggc_pkg::ggc_stat_t  st_new;
  logic [SW-1:0]       sum_w;
  logic                st_we;
  ggc_pkg::ggc_out_t   res;

  // --------------------------------------------------------------------------
  // issue control and clearing pass
  // --------------------------------------------------------------------------
  assign pending = (OCW+1)'(out_count) + (OCW+1)'(b_valid_q && b_cmd_q.fin)
                   + (OCW+1)'(c_valid_q);
  assign room    = pending < (OCW+1)'(ggc_pkg::OUT_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ggc_pkg::ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    pop_o      = 1'b0;
    issue      = 1'b0;
    vram_we    = 1'b0;
    vram_waddr = VW'(b_cmd_q.vertex);
    vram_wdata = chosen;
    case (state_q)
      ggc_pkg::ST_RUN: begin
        vram_we = b_wen;
        if (head_i.valid) begin
          if (head_i.cmd.kind == ggc_pkg::ACT_CLEAR) begin
            pop_o      = 1'b1;
            state_d    = ggc_pkg::ST_CLEAR;
            clr_addr_d = '0;
          end else if (!head_i.cmd.fin || room) begin
            pop_o = 1'b1;
            issue = 1'b1;
          end
        end
      end
      ggc_pkg::ST_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = clr_addr_q;
        vram_wdata = Uncolored;
        if (clr_addr_q == VW'(MAX_VERTICES - 1)) begin
          state_d = ggc_pkg::ST_RUN;
        end else begin
          clr_addr_d = clr_addr_q + VW'(1);
        end
      end
      default: begin
        state_d = ggc_pkg::ST_CLEAR;
      end
    endcase
  end

  ggc_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_VERTICES)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (issue),
    .raddr_i (VW'(head_i.cmd.neighbor)),
    .rdata_o (vram_rdata)
  );

  // --------------------------------------------------------------------------
  // mark stage: strike the neighbor's color, pick on the run's last item
  // --------------------------------------------------------------------------
  always_comb begin
    // the write of the previous vertex is not yet in the read data
    c_sel = (wb_valid_q && wb_addr_q == VW'(b_cmd_q.neighbor)) ? wb_data_q : vram_rdata;
    mark  = b_valid_q && (b_cmd_q.kind == ggc_pkg::ACT_NEIGHBOR) && !stop_q
            && b_cmd_q.in_range && (c_sel != Uncolored);
    deg_inc = (deg_q < DW'(MAX_DEGREE)) ? deg_q + DW'(1) : deg_q;
    for (int j = 0; j < UW; j++) begin
      mask_mk[j] = mask_q[j] && !(mark && (c_sel == CW'(j)));
    end
    if (b_cmd_q.kind == ggc_pkg::ACT_SOLO) begin
      mask_f = '1;
      deg_f  = '0;
    end else begin
      mask_f = mask_mk;
      deg_f  = deg_inc;
    end
    for (int j = 0; j < UW; j++) begin
      avail[j] = mask_f[j] && (CW'(j) < ct_q);
    end
    // lowest free color among the opened ones
    found = 1'b0;
    pick  = '0;
    for (int j = UW - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        pick  = CW'(j);
      end
    end
    b_fin  = b_valid_q && b_cmd_q.fin;
    fail   = 1'b0;
    fresh  = 1'b0;
    chosen = pick;
    ct_n   = ct_q;
    if (!found) begin
      if (ct_q >= CW'(COLOR_LIMIT - 1)) begin
        fail = 1'b1;
      end else begin
        chosen = ct_q;
        fresh  = 1'b1;
        ct_n   = ct_q + CW'(1);
      end
    end
    b_wen = b_fin && !fail && (32'(b_cmd_q.vertex) < MAX_VERTICES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      wb_valid_q <= 1'b0;
      mask_q     <= '1;
      deg_q      <= '0;
      stop_q     <= 1'b0;
      ct_q       <= '0;
    end else begin
      b_valid_q  <= issue;
      wb_valid_q <= b_wen && (state_q == ggc_pkg::ST_RUN);
      if (state_q == ggc_pkg::ST_CLEAR) begin
        mask_q <= '1;
        deg_q  <= '0;
        stop_q <= 1'b0;
        ct_q   <= '0;
      end else if (b_valid_q) begin
        if (b_cmd_q.fin) begin
          mask_q <= '1;
          deg_q  <= '0;
          stop_q <= 1'b0;
          ct_q   <= ct_n;
        end else if (b_cmd_q.kind == ggc_pkg::ACT_NEIGHBOR) begin
          mask_q <= mask_mk;
          deg_q  <= deg_inc;
          stop_q <= stop_q || !b_cmd_q.in_range;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_cmd_q <= head_i.cmd;
    end
    if (b_wen) begin
      wb_addr_q <= VW'(b_cmd_q.vertex);
      wb_data_q <= chosen;
    end
  end

  // --------------------------------------------------------------------------
  // statistics stage
  // --------------------------------------------------------------------------
  ggc_ram #(
    .WIDTH ($bits(ggc_pkg::ggc_stat_t)),
    .DEPTH (COLOR_LIMIT)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (c_chosen_q),
    .wdata_i (st_new),
    .re_i    (b_fin),
    .raddr_i (chosen),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q  <= 1'b0;
      sb_valid_q <= 1'b0;
    end else begin
      c_valid_q  <= b_fin;
      sb_valid_q <= st_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fin) begin
      c_vertex_q <= b_cmd_q.vertex;
      c_chosen_q <= chosen;
      c_fail_q   <= fail;
      c_fresh_q  <= fresh;
      c_deg_q    <= deg_f;
      c_ct_q     <= ct_n;
    end
    if (st_we) begin
      sb_addr_q <= c_chosen_q;
      sb_data_q <= st_new;
    end
  end

  always_comb begin
    // a newly opened color starts from zero
    if (c_fresh_q) begin
      st_old = '0;
    end else if (sb_valid_q && sb_addr_q == c_chosen_q) begin
      st_old = sb_data_q;
    end else begin
      st_old = ggc_pkg::ggc_stat_t'(st_rdata);
    end
    st_new.nodes = (st_old.nodes == ggc_pkg::NODES_MAX) ? st_old.nodes
                   : st_old.nodes + ggc_pkg::NODES_W'(1);
    sum_w        = {1'b0, st_old.dsum} + SW'(c_deg_q);
    st_new.dsum  = (sum_w > SW'(ggc_pkg::DSUM_MAX)) ? ggc_pkg::DSUM_MAX
                   : sum_w[ggc_pkg::DSUM_W-1:0];
    st_we        = c_valid_q && !c_fail_q;

    res.vertex_out  = c_vertex_q;
    res.ran_out     = c_fail_q;
    res.colors_used = ggc_pkg::COLOR_W'(c_ct_q);
    if (c_fail_q) begin
      res.color_out          = '0;
      res.nodes_in_color     = '0;
      res.neighbors_in_color = '0;
    end else begin
      res.color_out          = ggc_pkg::COLOR_W'(c_chosen_q);
      res.nodes_in_color     = st_new.nodes;
      res.neighbors_in_color = st_new.dsum;
    end
  end

  ggc_fifo #(
    .WIDTH ($bits(ggc_pkg::ggc_out_t)),
    .DEPTH (ggc_pkg::OUT_DEPTH)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (c_valid_q),
    .wdata_i (res),
    .pop_i   (out_valid_o && !out_stall_i),
    .rdata_o (out_data_o),
    .valid_o (out_valid_o),
    .full_o  (),
    .count_o (out_count)
  );

endmodule

// ===== src/greedy_graph_coloring_core.sv =====
// ----------------------------------------------------------------------------
// greedy_graph_coloring_core
// First-fit greedy graph coloring over runs of neighbor items.
//
// channel   signals                                  dir   handshake
// input     in_valid_i, in_stall_o, in_data_i        in    valid / stall
// result    out_valid_o, out_stall_i, out_data_o     out   valid / stall
// config    cfg_valid_i, cfg_ready_o, cfg_data_i     in    valid / ready
//
// One item per cycle on the input while in_stall_o is low; a result leaves
// once the run's last item has passed the color table read, the choice stage
// and the statistics read-modify-write.
// After reset and after every clear item the color table is swept, one
// entry per cycle through all MAX_VERTICES entries, while queued items wait.
// The result buffer holds four transfers; a stalled output fills it and
// then the command queue before in_stall_o rises.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_core #(
  parameter int unsigned MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COLOR_LIMIT  = ggc_pkg::COLOR_LIMIT_DEF,
  parameter int unsigned MAX_DEGREE   = ggc_pkg::MAX_DEGREE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ggc_pkg::ggc_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ggc_pkg::ggc_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ggc_pkg::COUNT_W-1:0] cfg_data_i
);

  ggc_pkg::ggc_qhead_t cmd_head;
  logic                cmd_pop;

  ggc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .head_o      (cmd_head),
    .pop_i       (cmd_pop)
  );

  ggc_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COLOR_LIMIT  (COLOR_LIMIT),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .pop_o       (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_head.valid)
    else $error("command popped from an empty queue");

  a_ran_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ran_out |->
      out_data_o.color_out == '0 && out_data_o.nodes_in_color == '0
      && out_data_o.neighbors_in_color == '0)
    else $error("failed coloring carries nonzero statistics");

  a_ran_out_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ran_out |->
      out_data_o.colors_used == ggc_pkg::COLOR_W'(COLOR_LIMIT - 1))
    else $error("ran out of colors before the limit");

  a_color_opened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ran_out |->
      (COLOR_LIMIT > 64 || out_data_o.color_out < out_data_o.colors_used)
      && out_data_o.nodes_in_color != '0)
    else $error("assigned color not opened or empty");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for greedy_graph_coloring_core. An item-level model of
// the first-fit coloring predicts every result from the accepted input
// items. Directed runs cover the basic cases and stopped scans. Random runs
// follow, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_V       = ggc_pkg::MAX_VERTICES_DEF;
  localparam int unsigned NUM_COLORS  = ggc_pkg::COLOR_LIMIT_DEF;
  localparam int unsigned UNCOLORED   = NUM_COLORS - 1;
  localparam int unsigned DEG_CAP     = ggc_pkg::MAX_DEGREE_DEF;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned SETTLE      = 16;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  ggc_pkg::ggc_in_t             in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  ggc_pkg::ggc_out_t            out_data_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [ggc_pkg::COUNT_W-1:0]  cfg_data_i  = '0;

  greedy_graph_coloring_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // coloring model state
  logic [ggc_pkg::COLOR_W-1:0] tbl_color [NUM_V];
  bit                          open_free [NUM_COLORS];
  logic [ggc_pkg::NODES_W-1:0] cnt_nodes [NUM_COLORS];
  logic [ggc_pkg::DSUM_W-1:0]  cnt_dsum  [NUM_COLORS];
  int unsigned                 colors_open;
  int unsigned                 run_len;
  bit                          run_halted;
  int unsigned                 vc_limit;
  ggc_pkg::ggc_out_t           expected_colorings [$];

  int unsigned       fail_count  = 0;
  int unsigned       burst_left  = 0;
  bit                pace_on     = 1'b1;
  int unsigned       quiet_count = 0;
  int unsigned       stall_mode  = 0;
  int unsigned       stall_left  = 0;
  ggc_pkg::ggc_out_t oldest;

  function automatic void new_run();
    for (int j = 0; j < NUM_COLORS; j++) open_free[j] = 1'b1;
    run_len    = 0;
    run_halted = 1'b0;
  endfunction

  function automatic void wipe_graph();
    for (int j = 0; j < NUM_V; j++) tbl_color[j] = ggc_pkg::COLOR_W'(UNCOLORED);
    for (int j = 0; j < NUM_COLORS; j++) begin
      cnt_nodes[j] = '0;
      cnt_dsum[j]  = '0;
    end
    colors_open = 0;
    new_run();
  endfunction

  function automatic ggc_pkg::ggc_out_t color_vertex(logic [ggc_pkg::VERTEX_W-1:0] v);
    ggc_pkg::ggc_out_t         res;
    int unsigned               pick;
    bit                        found;
    bit                        failed;
    logic [ggc_pkg::DSUM_W:0]  sum;
    found  = 1'b0;
    failed = 1'b0;
    pick   = 0;
    for (int j = 0; j < colors_open; j++) begin
      if (!found && open_free[j]) begin
        found = 1'b1;
        pick  = j;
      end
    end
    if (!found) begin
      if (colors_open >= NUM_COLORS - 1) begin
        failed = 1'b1;
      end else begin
        pick            = colors_open;
        cnt_nodes[pick] = '0;
        cnt_dsum[pick]  = '0;
        colors_open++;
      end
    end
    res             = '0;
    res.vertex_out  = v;
    res.colors_used = colors_open[ggc_pkg::COLOR_W-1:0];
    if (failed) begin
      res.ran_out = 1'b1;
    end else begin
      if (cnt_nodes[pick] != ggc_pkg::NODES_MAX) cnt_nodes[pick] = cnt_nodes[pick] + 1'b1;
      sum = {1'b0, cnt_dsum[pick]} + (ggc_pkg::DSUM_W + 1)'(run_len);
      cnt_dsum[pick]         = (sum > {1'b0, ggc_pkg::DSUM_MAX}) ? ggc_pkg::DSUM_MAX
                               : sum[ggc_pkg::DSUM_W-1:0];
      tbl_color[v]           = ggc_pkg::COLOR_W'(pick);
      res.color_out          = pick[ggc_pkg::COLOR_W-1:0];
      res.nodes_in_color     = cnt_nodes[pick];
      res.neighbors_in_color = cnt_dsum[pick];
    end
    new_run();
    return res;
  endfunction

  function automatic void predict_coloring(ggc_pkg::ggc_in_t item);
    case (item.action)
      ggc_pkg::ACT_CLEAR: begin
        wipe_graph();
      end
      ggc_pkg::ACT_SOLO: begin
        new_run();
        expected_colorings.push_back(color_vertex(item.vertex));
      end
      ggc_pkg::ACT_NEIGHBOR: begin
        if (run_len < DEG_CAP) run_len++;
        if (!run_halted) begin
          if (item.neighbor >= vc_limit) begin
            run_halted = 1'b1;
          end else if (tbl_color[item.neighbor] != UNCOLORED) begin
            open_free[tbl_color[item.neighbor]] = 1'b0;
          end
        end
        if (item.last) expected_colorings.push_back(color_vertex(item.vertex));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ggc_pkg::VERTEX_W-1:0] rand_id();
    return ggc_pkg::VERTEX_W'($urandom);
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // one transfer on the input channel; valid stays up for a following item
  task automatic send_item(logic [1:0] act, logic [ggc_pkg::VERTEX_W-1:0] v,
                           logic [ggc_pkg::VERTEX_W-1:0] n, bit fin);
    ggc_pkg::ggc_in_t item;
    item.action   = act;
    item.vertex   = v;
    item.neighbor = n;
    item.last     = fin;
    if (pace_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_coloring(item);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_colorings.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_vcount(int unsigned val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val[ggc_pkg::COUNT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vc_limit = val;
  endtask

  function automatic logic [ggc_pkg::VERTEX_W-1:0] pick_vertex(
    logic [ggc_pkg::VERTEX_W-1:0] pool [16]);
    if ($urandom_range(0, 3) == 0) return rand_id();
    return pool[$urandom_range(0, 15)];
  endfunction

  function automatic logic [ggc_pkg::VERTEX_W-1:0] pick_neighbor(
    logic [ggc_pkg::VERTEX_W-1:0] pool [16]);
    int unsigned r;
    int          t;
    r = $urandom_range(0, 99);
    if (r < 60) return pool[$urandom_range(0, 15)];
    if (r < 80) begin
      // hover around the scan boundary
      t = int'(vc_limit) + int'($urandom_range(0, 3)) - 2;
      if (t < 0) t = 0;
      if (t > NUM_V - 1) t = NUM_V - 1;
      return ggc_pkg::VERTEX_W'(t);
    end
    return rand_id();
  endfunction

  task automatic test_basics();
    write_vcount(ggc_pkg::VCOUNT_RESET);
    send_item(ggc_pkg::ACT_SOLO, 12'd0, 12'hFFF, 1'b0);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd1, 12'd0, 1'b1);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'hFFF, 12'd0, 1'b0);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'hFFF, 12'd1, 1'b1);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd2, 12'hFFF, 1'b1);
    send_item(ACT_UNUSED, 12'hFFF, 12'hFFF, 1'b1);
    // partial run dropped by a vertex without neighbors
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd3, 12'd0, 1'b0);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd3, 12'd0, 1'b0);
    send_item(ggc_pkg::ACT_SOLO, 12'd3, 12'd0, 1'b1);
    // recolor vertex 0 away from its first color
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd0, 12'd2, 1'b1);
    send_item(ggc_pkg::ACT_CLEAR, 12'hFFF, 12'hFFF, 1'b1);
    send_item(ggc_pkg::ACT_SOLO, 12'hFFF, 12'd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_scan_stop();
    write_vcount(2);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd7, 12'd1, 1'b0);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd7, 12'hFFF, 1'b0);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd7, 12'd0, 1'b1);
    write_vcount(1);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd8, 12'd0, 1'b0);
    send_item(ggc_pkg::ACT_NEIGHBOR, 12'd8, 12'hFFF, 1'b1);
    send_item(ggc_pkg::ACT_SOLO, 12'd9, 12'd0, 1'b0);
    wait_idle();
  endtask

  task automatic random_phase(int unsigned n_items);
    logic [ggc_pkg::VERTEX_W-1:0] pool [16];
    int unsigned                  sent;
    int unsigned                  r;
    int unsigned                  len;
    logic [ggc_pkg::VERTEX_W-1:0] v;
    sent = 0;
    for (int i = 0; i < 16; i++) begin
      pool[i] = (i < 8) ? ggc_pkg::VERTEX_W'($urandom_range(0, vc_limit - 1)) : rand_id();
    end
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(ACT_UNUSED, rand_id(), rand_id(), rand_bit());
      end else if (r < 3) begin
        send_item(ggc_pkg::ACT_CLEAR, rand_id(), rand_id(), rand_bit());
        sent++;
      end else if (r < 10) begin
        send_item(ggc_pkg::ACT_SOLO, pick_vertex(pool), rand_id(), rand_bit());
        sent++;
      end else begin
        if (r < 95) len = $urandom_range(1, 8);
        else if (r < 98) len = $urandom_range(9, 40);
        else len = $urandom_range(60, 80);
        v = pick_vertex(pool);
        // runs without a closing item merge into the next one
        for (int i = 0; i < len; i++) begin
          send_item(ggc_pkg::ACT_NEIGHBOR, v, pick_neighbor(pool), r >= 16 && i == len - 1);
        end
        sent += len;
      end
    end
    send_item(ggc_pkg::ACT_SOLO, pick_vertex(pool), rand_id(), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_mix();
    int unsigned limits [6];
    limits = '{4096, 1, 37, 4096, 2, 4096};
    limits[3] = $urandom_range(1, 4096);
    for (int p = 0; p < 6; p++) begin
      write_vcount(limits[p]);
      random_phase(230);
    end
  endtask

  // result side stalls on its own schedule
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 1);
      2:       out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= ((stall_left % 16) < 5);
    endcase
  end

  function automatic void log_failure(string what, ggc_pkg::ggc_out_t exp,
                                      ggc_pkg::ggc_out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected v=%0d c=%0d ro=%0b used=%0d nodes=%0d nbrs=%0d",
               what, exp.vertex_out, exp.color_out, exp.ran_out, exp.colors_used,
               exp.nodes_in_color, exp.neighbors_in_color);
      $display("  got v=%0d c=%0d ro=%0b used=%0d nodes=%0d nbrs=%0d",
               got.vertex_out, got.color_out, got.ran_out, got.colors_used,
               got.nodes_in_color, got.neighbors_in_color);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_colorings.size() == 0) begin
        log_failure("unexpected result", '0, out_data_o);
      end else begin
        oldest = expected_colorings.pop_front();
        if (out_data_o.vertex_out !== oldest.vertex_out ||
            out_data_o.color_out !== oldest.color_out ||
            out_data_o.ran_out !== oldest.ran_out ||
            out_data_o.colors_used !== oldest.colors_used ||
            out_data_o.nodes_in_color !== oldest.nodes_in_color ||
            out_data_o.neighbors_in_color !== oldest.neighbors_in_color) begin
          log_failure("result mismatch", oldest, out_data_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    wipe_graph();
    vc_limit = ggc_pkg::VCOUNT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basics();
    test_scan_stop();
    test_random_mix();
    wait_idle();
    if (fail_count == 0 && expected_colorings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
